// ===== hw/rtl/conv3x3_image_filter_unit_defines.svh =====
// Assertion macros used by the convolution filter top level.
`ifndef CONV3X3_IMAGE_FILTER_UNIT_DEFINES_SVH
`define CONV3X3_IMAGE_FILTER_UNIT_DEFINES_SVH
`ifndef SYNTH
`define C3F_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("conv3x3 filter: check failed");
`define C3F_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("conv3x3 filter: check failed");
`else
`define C3F_ASSERT_IMP(lbl, ante, cons)
`define C3F_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== hw/rtl/c3f_pkg.sv =====
// Shared types and constants of the 3x3 convolution filter.
`default_nettype none
package c3f_pkg;

  localparam int MAX_WIDTH      = 2048;
  localparam int MAX_HEIGHT     = 4096;
  localparam int COEF_FRAC_BITS = 8;

  // Depth of the queue between front and back, and of the result queue.
  localparam int MID_DEPTH = 4;
  localparam int QCW       = $clog2(MID_DEPTH + 1);
  localparam int OUT_DEPTH = 8;

  localparam logic [11:0] WIDTH_RST  = 12'd640;
  localparam logic [12:0] HEIGHT_RST = 13'd480;
  localparam logic [47:0] KTOP_RST   = 48'h0000_0000_0000;
  localparam logic [47:0] KMID_RST   = 48'h0000_0100_0000;
  localparam logic [47:0] KBOT_RST   = 48'h0000_0000_0000;

  typedef enum logic [2:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_KTOP   = 3'd2,
    REG_KMID   = 3'd3,
    REG_KBOT   = 3'd4
  } cfg_reg_e;

  // One 3x3 neighbourhood; px[row][pos], row 0 is the oldest line, pos 0 the left column.
  typedef struct packed {
    logic [2:0][2:0][7:0] px;
    logic                 line_end;
    logic                 frame_end;
  } win_t;

endpackage
`default_nettype wire

// ===== hw/rtl/c3f_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module c3f_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== hw/rtl/c3f_fifo.sv =====
// Small register-based first-in first-out queue.
`default_nettype none
module c3f_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       push_i,
  input  wire logic [WIDTH-1:0]           wdata_i,
  input  wire logic                       pop_i,
  output logic      [WIDTH-1:0]           rdata_o,
  output logic                            empty_o,
  output logic      [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]    count_q, count_d;

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push_i) begin
      wptr_d = (32'(wptr_q) == DEPTH - 1) ? '0 : wptr_q + AW'(1);
    end
    if (pop_i) begin
      rptr_d = (32'(rptr_q) == DEPTH - 1) ? '0 : rptr_q + AW'(1);
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + CW'(1);
      2'b01:   count_d = count_q - CW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  assign rdata_o = mem_q[rptr_q];
  assign empty_o = (count_q == '0);
  assign count_o = count_q;

endmodule
`default_nettype wire

// ===== hw/rtl/c3f_front.sv =====
// Front end: pixel intake, position counters, line buffers and the 3x3 window.
`default_nettype none
module c3f_front #(
  parameter int MAX_WIDTH = c3f_pkg::MAX_WIDTH
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    push_i,
  output logic                         full_o,
  input  wire logic [7:0]              pixel_in_i,
  input  wire logic                    frame_start_i,
  input  wire logic [11:0]             img_width_i,
  input  wire logic [12:0]             img_height_i,
  input  wire logic [c3f_pkg::QCW-1:0] q_count_i,
  output logic                         q_push_o,
  output c3f_pkg::win_t                q_win_o
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WEW = $clog2(MAX_WIDTH + 1);

  logic           accept;
  logic [WEW-1:0] w_eff;
  logic [12:0]    h_eff;

  logic [CW-1:0]  col_q, col_d, c0, c1;
  logic [11:0]    row_q, row_d, r0, r2;
  logic [12:0]    r1;
  logic           wrap_col, emit, le, last_row;

  logic           s1_valid_q, s1_emit_q, s1_le_q, s1_fe_q;
  logic [7:0]     s1_px_q;
  logic [CW-1:0]  s1_addr_q;

  logic           byp_hit_q;
  logic [15:0]    byp_data_q;
  logic [15:0]    ram_rdata, lines;
  logic [2:0][7:0] col;
  logic [5:0][7:0] win_q, win_d;

  // The queue must have room for this beat and the one in the window stage.
  assign full_o = ({1'b0, q_count_i} + (c3f_pkg::QCW + 1)'(s1_valid_q))
                  >= (c3f_pkg::QCW + 1)'(c3f_pkg::MID_DEPTH);
  assign accept = push_i && !full_o;

  always_comb begin
    if (img_width_i < 12'd3) begin
      w_eff = WEW'(3);
    end else if (32'(img_width_i) > 32'(MAX_WIDTH)) begin
      w_eff = WEW'(MAX_WIDTH);
    end else begin
      w_eff = WEW'(img_width_i);
    end
    if (img_height_i < 13'd3) begin
      h_eff = 13'd3;
    end else if (img_height_i > 13'(c3f_pkg::MAX_HEIGHT)) begin
      h_eff = 13'(c3f_pkg::MAX_HEIGHT);
    end else begin
      h_eff = img_height_i;
    end
  end

  // Position of the incoming pixel, after a frame restart or a shrunk frame size.
  always_comb begin
    c0       = frame_start_i ? '0 : col_q;
    r0       = frame_start_i ? '0 : row_q;
    wrap_col = WEW'(c0) >= w_eff;
    c1       = wrap_col ? '0 : c0;
    r1       = wrap_col ? {1'b0, r0} + 13'd1 : {1'b0, r0};
    r2       = (r1 >= h_eff) ? 12'd0 : r1[11:0];
    le       = WEW'(c1) == (w_eff - WEW'(1));
    last_row = {1'b0, r2} == (h_eff - 13'd1);
    emit     = (WEW'(c1) >= WEW'(2)) && (r2 >= 12'd2);
    if (le) begin
      col_d = '0;
      row_d = last_row ? 12'd0 : r2 + 12'd1;
    end else begin
      col_d = c1 + CW'(1);
      row_d = r2;
    end
  end

  c3f_ram #(
    .WIDTH (16),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_addr_q),
    .wdata_i ({s1_px_q, col[1]}),
    .re_i    (accept),
    .raddr_i (c1),
    .rdata_o (ram_rdata)
  );

  // A read of the column still being written in the window stage takes the new data.
  assign lines  = byp_hit_q ? byp_data_q : ram_rdata;
  assign col[0] = lines[7:0];
  assign col[1] = lines[15:8];
  assign col[2] = s1_px_q;

  always_comb begin
    win_d = win_q;
    if (s1_valid_q) begin
      for (int r = 0; r < 3; r++) begin
        win_d[2*r]   = win_q[2*r+1];
        win_d[2*r+1] = col[r];
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      q_win_o.px[r][0] = win_q[2*r];
      q_win_o.px[r][1] = win_q[2*r+1];
      q_win_o.px[r][2] = col[r];
    end
    q_win_o.line_end  = s1_le_q;
    q_win_o.frame_end = s1_fe_q;
  end

  assign q_push_o = s1_valid_q && s1_emit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
      byp_hit_q  <= 1'b0;
      win_q      <= '0;
    end else begin
      s1_valid_q <= accept;
      byp_hit_q  <= accept && s1_valid_q && (c1 == s1_addr_q);
      win_q      <= win_d;
      if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    byp_data_q <= {s1_px_q, col[1]};
    if (accept) begin
      s1_px_q   <= pixel_in_i;
      s1_addr_q <= c1;
      s1_emit_q <= emit;
      s1_le_q   <= le;
      s1_fe_q   <= le && last_row;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/c3f_back.sv =====
// Back end: multiply-accumulate pipeline, truncation, saturation and result queue.
`default_nettype none
module c3f_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                q_empty_i,
  input  wire c3f_pkg::win_t       q_win_i,
  output logic                     q_pop_o,
  input  wire logic [2:0][47:0]    kernel_i,
  input  wire logic                pop_i,
  output logic                     empty_o,
  output logic      [7:0]          pixel_out_o,
  output logic                     line_end_o,
  output logic                     frame_end_o
);

  localparam int F   = c3f_pkg::COEF_FRAC_BITS;
  localparam int OCW = $clog2(c3f_pkg::OUT_DEPTH + 1);
  localparam int LW  = OCW + 1;

  logic               b1_valid_q, b2_valid_q, b3_valid_q;
  logic [1:0]         b1_flags_q, b2_flags_q, b3_flags_q;
  logic signed [24:0] prod_d [3][3];
  logic signed [24:0] prod_q [3][3];
  logic signed [26:0] rsum_q [3];
  logic signed [28:0] total_q;
  logic [7:0]         sat;
  logic [OCW-1:0]     out_count;
  logic [9:0]         out_rdata;
  logic               out_empty;
  logic [LW-1:0]      pending;

  // Every beat in flight already owns a slot of the result queue.
  assign pending = LW'(out_count) + LW'(b1_valid_q) + LW'(b2_valid_q) + LW'(b3_valid_q);
  assign q_pop_o = !q_empty_i && (pending < LW'(c3f_pkg::OUT_DEPTH));

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int p = 0; p < 3; p++) begin
        prod_d[r][p] = 25'(signed'({1'b0, q_win_i.px[r][p]})
                       * signed'(kernel_i[r][16*p +: 16]));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q <= 1'b0;
      b2_valid_q <= 1'b0;
      b3_valid_q <= 1'b0;
    end else begin
      b1_valid_q <= q_pop_o;
      b2_valid_q <= b1_valid_q;
      b3_valid_q <= b2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 3; r++) begin
      for (int p = 0; p < 3; p++) begin
        prod_q[r][p] <= prod_d[r][p];
      end
      rsum_q[r] <= 27'(prod_q[r][0]) + 27'(prod_q[r][1]) + 27'(prod_q[r][2]);
    end
    total_q    <= 29'(rsum_q[0]) + 29'(rsum_q[1]) + 29'(rsum_q[2]);
    b1_flags_q <= {q_win_i.line_end, q_win_i.frame_end};
    b2_flags_q <= b1_flags_q;
    b3_flags_q <= b2_flags_q;
  end

  // A sum that is zero or negative gives black; a large one clips to white.
  always_comb begin
    if (total_q[28] || (total_q == '0)) begin
      sat = 8'd0;
    end else if (|total_q[27:F+8]) begin
      sat = 8'd255;
    end else begin
      sat = total_q[F+7:F];
    end
  end

  c3f_fifo #(
    .WIDTH (10),
    .DEPTH (c3f_pkg::OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (b3_valid_q),
    .wdata_i ({sat, b3_flags_q}),
    .pop_i   (pop_i && !out_empty),
    .rdata_o (out_rdata),
    .empty_o (out_empty),
    .count_o (out_count)
  );

  assign empty_o     = out_empty;
  assign pixel_out_o = out_rdata[9:2];
  assign line_end_o  = out_rdata[1];
  assign frame_end_o = out_rdata[0];

endmodule
`default_nettype wire

// ===== hw/rtl/conv3x3_image_filter_unit.sv =====
// Streaming 3x3 convolution filter for 8-bit grayscale pixels: top level.
// Pixels go in through a queue-like port (push/full) in raster order, one per clock while
// full is low, and results come out of a queue-like port (empty/pop). Only pixels whose
// whole 3x3 neighbourhood lies inside the frame give a result, flagged line_end and
// frame_end on the last result of a line and of a frame. The rate of one pixel per cycle
// is set by the line buffer RAM, which takes one read and one write of a column per
// pixel; the line buffers need no clearing after reset, and the first two lines of each
// frame produce no output. Configuration writes must be made only while the block is
// idle.
`default_nettype none
`include "conv3x3_image_filter_unit_defines.svh"
module conv3x3_image_filter_unit #(
  parameter int MAX_WIDTH = c3f_pkg::MAX_WIDTH
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [47:0] cfg_wdata_i,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  pixel_in_i,
  input  wire logic        frame_start_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       pixel_out_o,
  output logic             line_end_o,
  output logic             frame_end_o
);

  logic [11:0]             width_q;
  logic [12:0]             height_q;
  logic [2:0][47:0]        kern_q;

  logic                    mid_push, mid_pop, mid_empty;
  logic [c3f_pkg::QCW-1:0] mid_count;
  c3f_pkg::win_t           mid_wdata, mid_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= c3f_pkg::WIDTH_RST;
      height_q  <= c3f_pkg::HEIGHT_RST;
      kern_q[0] <= c3f_pkg::KTOP_RST;
      kern_q[1] <= c3f_pkg::KMID_RST;
      kern_q[2] <= c3f_pkg::KBOT_RST;
    end else if (cfg_we_i) begin
      case (c3f_pkg::cfg_reg_e'(cfg_idx_i))
        c3f_pkg::REG_WIDTH:  width_q   <= cfg_wdata_i[11:0];
        c3f_pkg::REG_HEIGHT: height_q  <= cfg_wdata_i[12:0];
        c3f_pkg::REG_KTOP:   kern_q[0] <= cfg_wdata_i;
        c3f_pkg::REG_KMID:   kern_q[1] <= cfg_wdata_i;
        c3f_pkg::REG_KBOT:   kern_q[2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  c3f_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .pixel_in_i    (pixel_in_i),
    .frame_start_i (frame_start_i),
    .img_width_i   (width_q),
    .img_height_i  (height_q),
    .q_count_i     (mid_count),
    .q_push_o      (mid_push),
    .q_win_o       (mid_wdata)
  );

  c3f_fifo #(
    .WIDTH ($bits(c3f_pkg::win_t)),
    .DEPTH (c3f_pkg::MID_DEPTH)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .wdata_i (mid_wdata),
    .pop_i   (mid_pop),
    .rdata_o (mid_rdata),
    .empty_o (mid_empty),
    .count_o (mid_count)
  );

  c3f_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (mid_empty),
    .q_win_i     (mid_rdata),
    .q_pop_o     (mid_pop),
    .kernel_i    (kern_q),
    .pop_i       (pop),
    .empty_o     (empty),
    .pixel_out_o (pixel_out_o),
    .line_end_o  (line_end_o),
    .frame_end_o (frame_end_o)
  );

  `C3F_ASSERT_IMP(a_mid_no_overflow, mid_push && !mid_pop,
                  32'(mid_count) < c3f_pkg::MID_DEPTH)
  `C3F_ASSERT_IMP(a_full_has_backlog, full, 32'(mid_count) >= c3f_pkg::MID_DEPTH - 1)
  `C3F_ASSERT_NXT(a_mid_push_lands, mid_push, mid_count != '0)
  `C3F_ASSERT_IMP(a_frame_end_ends_line, !empty, !frame_end_o || line_end_o)

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking testbench of the 3x3 convolution filter, with its own line-buffer predictor.
module testbench;
  import c3f_pkg::*;

  localparam int ITEMS        = 1000;
  localparam int DRAIN_CYCLES = 32;
  localparam int STALL_LIMIT  = 2000;
  localparam int MAX_REPORTS  = 10;

  localparam logic [2:0]  REG_IDX_TOP  = 3'd7;
  localparam logic [15:0] COEF_POS_MAX = 16'h7FFF;
  localparam logic [15:0] COEF_NEG_MAX = 16'h8000;
  localparam logic [15:0] COEF_ONE     = 16'h0100;

  typedef enum int {K_RANDOM, K_SMALL, K_SMOOTH, K_PASS} kernel_style_e;

  typedef struct packed {
    logic [7:0] pixel;
    logic       line_end;
    logic       frame_end;
  } filt_res_t;

  class conv_scoreboard;
    logic [11:0] width;
    logic [12:0] height;
    logic [47:0] kernel [3];
    logic [7:0]  line_old [MAX_WIDTH];
    logic [7:0]  line_prev [MAX_WIDTH];
    logic [7:0]  window [6];
    int unsigned col_cnt;
    int unsigned row_cnt;
    int unsigned lb_extent;
    int unsigned failures;
    filt_res_t   expected_q [$];

    function new();
      width     = WIDTH_RST;
      height    = HEIGHT_RST;
      kernel[0] = KTOP_RST;
      kernel[1] = KMID_RST;
      kernel[2] = KBOT_RST;
      foreach (line_old[i]) begin
        line_old[i]  = '0;
        line_prev[i] = '0;
      end
      foreach (window[i]) window[i] = '0;
      col_cnt   = 0;
      row_cnt   = 0;
      lb_extent = 0;
      failures  = 0;
    endfunction

    function int unsigned used_width();
      if (width < 3) return 3;
      if (width > MAX_WIDTH) return MAX_WIDTH;
      return width;
    endfunction

    function int unsigned used_height();
      if (height < 3) return 3;
      if (height > MAX_HEIGHT) return MAX_HEIGHT;
      return height;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void write_reg(logic [2:0] idx, logic [47:0] data);
      case (idx)
        REG_WIDTH:  width = data[11:0];
        REG_HEIGHT: height = data[12:0];
        REG_KTOP:   kernel[0] = data;
        REG_KMID:   kernel[1] = data;
        REG_KBOT:   kernel[2] = data;
        default: ;
      endcase
    endfunction

    function void note_pixel(logic [7:0] px, logic fs);
      int unsigned w;
      int unsigned h;
      int          r;
      logic [7:0]  col [3];
      logic signed [15:0] k;
      longint      sum;
      filt_res_t   res;
      w = used_width();
      h = used_height();
      if (fs) begin
        col_cnt = 0;
        row_cnt = 0;
      end
      // A size change can leave the counters beyond the new frame.
      if (col_cnt >= w) begin
        col_cnt = 0;
        row_cnt++;
      end
      if (row_cnt >= h) row_cnt = 0;
      col[0] = line_old[col_cnt];
      col[1] = line_prev[col_cnt];
      col[2] = px;
      if (col_cnt >= 2 && row_cnt >= 2) begin
        sum = 0;
        for (r = 0; r < 3; r++) begin
          k = kernel[r][15:0];
          sum += longint'(window[2 * r]) * longint'(k);
          k = kernel[r][31:16];
          sum += longint'(window[2 * r + 1]) * longint'(k);
          k = kernel[r][47:32];
          sum += longint'(col[r]) * longint'(k);
        end
        if (sum <= 0) res.pixel = '0;
        else if ((sum >>> COEF_FRAC_BITS) > 255) res.pixel = 8'hFF;
        else res.pixel = 8'(sum >>> COEF_FRAC_BITS);
        res.line_end  = (col_cnt == w - 1);
        res.frame_end = (col_cnt == w - 1) && (row_cnt == h - 1);
        expected_q.push_back(res);
      end
      for (r = 0; r < 3; r++) begin
        window[2 * r]     = window[2 * r + 1];
        window[2 * r + 1] = col[r];
      end
      line_old[col_cnt]  = col[1];
      line_prev[col_cnt] = px;
      if (col_cnt + 1 > lb_extent) lb_extent = col_cnt + 1;
      col_cnt++;
      if (col_cnt >= w) begin
        col_cnt = 0;
        row_cnt++;
        if (row_cnt >= h) row_cnt = 0;
      end
    endfunction

    function void check_result(logic [7:0] px, logic le, logic fe);
      filt_res_t want;
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("unexpected result beat: pixel_out=%0d line_end=%b frame_end=%b",
                   px, le, fe);
        return;
      end
      want = expected_q.pop_front();
      if (px !== want.pixel || le !== want.line_end || fe !== want.frame_end) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("result mismatch: expected pixel_out=%0d line_end=%b frame_end=%b, %s",
                   want.pixel, want.line_end, want.frame_end,
                   $sformatf("got pixel_out=%0d line_end=%b frame_end=%b", px, le, fe));
      end
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [2:0]  cfg_idx_i     = '0;
  logic [47:0] cfg_wdata_i   = '0;
  logic        push          = 1'b0;
  logic        full;
  logic [7:0]  pixel_in_i    = '0;
  logic        frame_start_i = 1'b0;
  logic        empty;
  logic        pop           = 1'b0;
  logic [7:0]  pixel_out_o;
  logic        line_end_o;
  logic        frame_end_o;

  int unsigned send_idle_pct = 12;
  int unsigned recv_idle_pct = 76;
  int unsigned stall_cycles  = 0;
  conv_scoreboard sb;

  conv3x3_image_filter_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .push          (push),
    .full          (full),
    .pixel_in_i    (pixel_in_i),
    .frame_start_i (frame_start_i),
    .empty         (empty),
    .pop           (pop),
    .pixel_out_o   (pixel_out_o),
    .line_end_o    (line_end_o),
    .frame_end_o   (frame_end_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) sb.check_result(pixel_out_o, line_end_o, frame_end_o);
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic logic [47:0] rand48();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[47:0];
  endfunction

  function automatic logic [47:0] kernel_row(kernel_style_e style, int unsigned row);
    logic [15:0] c [3];
    int          v;
    int unsigned p;
    for (p = 0; p < 3; p++) begin
      case (style)
        K_RANDOM: c[p] = 16'($urandom);
        K_SMALL: begin
          v    = int'($urandom_range(128)) - 64;
          c[p] = 16'(v);
        end
        K_SMOOTH: c[p] = 16'($urandom_range(28));
        default:  c[p] = (row == 1 && p == 1) ? COEF_ONE : '0;
      endcase
    end
    return {c[2], c[1], c[0]};
  endfunction

  task automatic send_pixel(input logic [7:0] px, input logic fs);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push          <= 1'b1;
    pixel_in_i    <= px;
    frame_start_i <= fs;
    @(posedge clk_i);
    while (full !== 1'b0) @(posedge clk_i);
    sb.note_pixel(px, fs);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [47:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  task automatic configure(input logic [11:0] w, input logic [12:0] h,
                           input logic [47:0] k_top, input logic [47:0] k_mid,
                           input logic [47:0] k_bot);
    logic [47:0] junk;
    junk = rand48();
    // Bits above each register's width must be dropped by the block.
    write_reg(REG_WIDTH, {junk[35:0], w});
    write_reg(REG_HEIGHT, {junk[34:0], h});
    write_reg(REG_KTOP, k_top);
    write_reg(REG_KMID, k_mid);
    write_reg(REG_KBOT, k_bot);
    // An index past the register list must leave every setting alone.
    write_reg(3'($urandom_range(REG_IDX_TOP, REG_KBOT + 1)), rand48());
    cfg_we_i <= 1'b0;
  endtask

  task automatic settle();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic drive_pixels(input int unsigned n, input bit first_fs,
                              input int unsigned noise_pct);
    bit          restart;
    logic        fs;
    int unsigned i;
    // Growing past the columns ever written would read stale buffer entries, so
    // such a frame is restarted and the first two lines refill the buffers.
    restart = first_fs || (sb.used_width() > sb.lb_extent);
    for (i = 0; i < n; i++) begin
      fs = (i == 0 && restart) || ($urandom_range(99) < noise_pct);
      send_pixel(8'($urandom_range(255)), fs);
    end
    settle();
  endtask

  initial begin
    int unsigned   random_items;
    int unsigned   i;
    int unsigned   n;
    logic [11:0]   w;
    logic [12:0]   h;
    kernel_style_e style;

    sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Out-of-range sizes clamp to 3x3; the largest coefficients drive the sum to saturation.
    configure(12'd0, 13'd1, {3{COEF_POS_MAX}}, {3{COEF_POS_MAX}}, {3{COEF_POS_MAX}});
    for (i = 0; i < 9; i++) send_pixel((i == 4) ? 8'h01 : 8'hFF, i == 0);
    settle();
    // The most negative coefficients give sums below zero, which clamp to zero.
    // No frame_start here: the counters wrapped at the end of the previous frame.
    configure(12'd3, 13'd3, {3{COEF_NEG_MAX}}, {3{COEF_NEG_MAX}}, {3{COEF_NEG_MAX}});
    for (i = 0; i < 9; i++) send_pixel(i[0] ? 8'hFF : 8'h00, 1'b0);
    settle();

    random_items = 0;
    while (random_items < ITEMS) begin
      if (random_items < ITEMS / 3) begin
        send_idle_pct = 12;
        recv_idle_pct = 76;
      end else if (random_items < 2 * ITEMS / 3) begin
        send_idle_pct = 76;
        recv_idle_pct = 12;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case ($urandom_range(9))
        0:       w = 12'($urandom_range(2));
        1:       w = 12'($urandom_range(24, 9));
        default: w = 12'($urandom_range(8, 3));
      endcase
      case ($urandom_range(9))
        0:       h = 13'($urandom_range(2));
        1:       h = 13'($urandom_range(10, 7));
        default: h = 13'($urandom_range(6, 3));
      endcase
      style = kernel_style_e'($urandom_range(K_PASS));
      configure(w, h, kernel_row(style, 0), kernel_row(style, 1), kernel_row(style, 2));
      // One to three whole frames plus up to two more lines, so often stopping mid-frame before the next size change.
      n = sb.used_width() * sb.used_height() * $urandom_range(3, 1)
          + $urandom_range(2 * sb.used_width());
      drive_pixels(n, $urandom_range(1), 2);
      random_items += n;
    end

    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
